// ----- src/jse_pkg.sv -----
// Shared types, character constants and helpers for the JSON string escape encoder.
package jse_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned UnitW      = 16;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned StepW      = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  localparam logic [UnitW-1:0] CH_QUOTE = 16'h0022;
  localparam logic [UnitW-1:0] CH_BSL   = 16'h005C;
  localparam logic [UnitW-1:0] CH_BS    = 16'h0008;
  localparam logic [UnitW-1:0] CH_FF    = 16'h000C;
  localparam logic [UnitW-1:0] CH_LF    = 16'h000A;
  localparam logic [UnitW-1:0] CH_CR    = 16'h000D;
  localparam logic [UnitW-1:0] CH_TAB   = 16'h0009;
  localparam logic [UnitW-1:0] CH_B     = 16'h0062;
  localparam logic [UnitW-1:0] CH_F     = 16'h0066;
  localparam logic [UnitW-1:0] CH_N     = 16'h006E;
  localparam logic [UnitW-1:0] CH_R     = 16'h0072;
  localparam logic [UnitW-1:0] CH_T     = 16'h0074;
  localparam logic [UnitW-1:0] CH_U     = 16'h0075;
  localparam logic [UnitW-1:0] CH_ZERO  = 16'h0030;
  localparam logic [UnitW-1:0] CH_A     = 16'h0061;
  localparam logic [UnitW-1:0] CTRL_MAX = 16'd31;

  // What the back end has to emit for one transaction.
  typedef enum logic [1:0] {
    K_QUOTE = 2'd0,
    K_PLAIN = 2'd1,
    K_ESC2  = 2'd2,
    K_UHEX  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [UnitW-1:0] arg;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic mid_item;
  } bk_stat_t;

  function automatic logic [UnitW-1:0] hex_digit(input logic [3:0] v);
    logic [UnitW-1:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {12'd0, v};
    end else begin
      r = CH_A + {12'd0, v} - 16'd10;
    end
    return r;
  endfunction

  function automatic logic [StepW-1:0] kind_len(input kind_t k);
    logic [StepW-1:0] n;
    case (k)
      K_QUOTE: n = 3'd1;
      K_PLAIN: n = 3'd1;
      K_ESC2:  n = 3'd2;
      K_UHEX:  n = 3'd6;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

// ----- src/jse_if.sv -----
// Valid/ready channel interfaces for the encoder input and output streams.
interface jse_in_if;
  logic                        valid;
  logic                        ready;
  logic [jse_pkg::CmdW-1:0]    cmd;
  logic [jse_pkg::UnitW-1:0]   code_unit;

  modport source (output valid, cmd, code_unit, input ready);
  modport sink   (input valid, cmd, code_unit, output ready);
endinterface

interface jse_out_if;
  logic                        valid;
  logic                        ready;
  logic [jse_pkg::UnitW-1:0]   out_char;
  logic                        last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

// ----- src/jse_front.sv -----
// Front end: accepts input transactions and classifies them into escape descriptors.
module jse_front (
  jse_in_if.sink                in_ch,
  input  jse_pkg::q_stat_t      q_stat,
  output logic                  push,
  output jse_pkg::desc_t        push_desc
);

  logic cmd_ok;

  assign in_ch.ready = !q_stat.full;

  always_comb begin
    cmd_ok         = 1'b1;
    push_desc.kind = jse_pkg::K_QUOTE;
    push_desc.arg  = jse_pkg::CH_QUOTE;
    case (in_ch.cmd)
      jse_pkg::CMD_OPEN, jse_pkg::CMD_CLOSE: begin
        push_desc.kind = jse_pkg::K_QUOTE;
        push_desc.arg  = jse_pkg::CH_QUOTE;
      end
      jse_pkg::CMD_CHAR: begin
        push_desc.kind = jse_pkg::K_ESC2;
        push_desc.arg  = in_ch.code_unit;
        case (in_ch.code_unit)
          jse_pkg::CH_QUOTE, jse_pkg::CH_BSL: push_desc.arg = in_ch.code_unit;
          jse_pkg::CH_BS:  push_desc.arg = jse_pkg::CH_B;
          jse_pkg::CH_FF:  push_desc.arg = jse_pkg::CH_F;
          jse_pkg::CH_LF:  push_desc.arg = jse_pkg::CH_N;
          jse_pkg::CH_CR:  push_desc.arg = jse_pkg::CH_R;
          jse_pkg::CH_TAB: push_desc.arg = jse_pkg::CH_T;
          default: begin
            if (in_ch.code_unit <= jse_pkg::CTRL_MAX) begin
              push_desc.kind = jse_pkg::K_UHEX;
            end else begin
              push_desc.kind = jse_pkg::K_PLAIN;
            end
          end
        endcase
      end
      default: cmd_ok = 1'b0;  // unused command: accepted and dropped
    endcase
  end

  assign push = in_ch.valid && in_ch.ready && cmd_ok;

endmodule

// ----- src/jse_queue.sv -----
// Short descriptor queue between the front and back ends.
module jse_queue #(
  parameter int unsigned DEPTH = jse_pkg::QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  jse_pkg::desc_t        push_desc,
  input  logic                  pop,
  output jse_pkg::desc_t        head,
  output jse_pkg::q_stat_t      q_stat
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  jse_pkg::desc_t  mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == FullCnt);
  assign q_stat.empty = (cnt_r == '0);

endmodule

// ----- src/jse_back.sv -----
// Back end: expands each descriptor into output code units through an output register.
module jse_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jse_pkg::desc_t        head,
  input  jse_pkg::q_stat_t      q_stat,
  output logic                  pop,
  output jse_pkg::bk_stat_t     bk_stat,
  jse_out_if.source             out_ch
);

  logic [jse_pkg::StepW-1:0] step_r, step_nxt;
  logic                      vld_r, vld_nxt;
  logic [jse_pkg::UnitW-1:0] char_r;
  logic                      last_r;
  logic [jse_pkg::UnitW-1:0] emit_char;
  logic                      emit_last;
  logic                      load;

  always_comb begin
    emit_char = jse_pkg::CH_BSL;
    case (head.kind)
      jse_pkg::K_QUOTE: emit_char = jse_pkg::CH_QUOTE;
      jse_pkg::K_PLAIN: emit_char = head.arg;
      jse_pkg::K_ESC2:  emit_char = (step_r == 3'd0) ? jse_pkg::CH_BSL : head.arg;
      jse_pkg::K_UHEX: begin
        case (step_r)
          3'd0:    emit_char = jse_pkg::CH_BSL;
          3'd1:    emit_char = jse_pkg::CH_U;
          3'd2:    emit_char = jse_pkg::hex_digit(head.arg[15:12]);
          3'd3:    emit_char = jse_pkg::hex_digit(head.arg[11:8]);
          3'd4:    emit_char = jse_pkg::hex_digit(head.arg[7:4]);
          default: emit_char = jse_pkg::hex_digit(head.arg[3:0]);
        endcase
      end
      default: emit_char = jse_pkg::CH_BSL;
    endcase
  end

  assign emit_last = (step_r == jse_pkg::kind_len(head.kind) - 3'd1);
  // output slot frees up when empty or being taken this cycle
  assign load      = !q_stat.empty && (!vld_r || out_ch.ready);
  assign pop       = load && emit_last;

  always_comb begin
    step_nxt = step_r;
    vld_nxt  = vld_r;
    if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt  = 1'b1;
      step_nxt = emit_last ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= emit_char;
      last_r <= emit_last;
    end
  end

  assign out_ch.valid     = vld_r;
  assign out_ch.out_char  = char_r;
  assign out_ch.last      = last_r;
  assign bk_stat.mid_item = (step_r != '0);

endmodule

// ----- src/json_string_escape_encoder_core.sv -----
// Top level of the JSON string escape encoder: front end, descriptor queue, back end.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | cmd[1:0], code_unit[15:0]
//  out_ch  | out | valid/ready   | out_char[15:0], last
//
// Plain characters, open and close each give one output unit in the back end; the
// two-character escapes give two and the \u form gives six, one output unit per
// cycle through the back end's output register while out_ch is not stalled. The
// front end accepts a transaction every cycle while the DEPTH-entry queue has room.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// Output stalls back up into the queue; input stalls only when it is full.
module json_string_escape_encoder_core #(
  parameter int unsigned DEPTH = jse_pkg::QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  jse_in_if.sink    in_ch,
  jse_out_if.source out_ch
);

  logic               push;
  logic               pop;
  jse_pkg::desc_t     push_desc;
  jse_pkg::desc_t     head;
  jse_pkg::q_stat_t   q_stat;
  jse_pkg::bk_stat_t  bk_stat;

  jse_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  jse_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  jse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .bk_stat (bk_stat),
    .out_ch  (out_ch)
  );

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_ch.ready)
    else $error("input ready while queue full");

  a_escape_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("escape sequence broken off");

  a_idle_step_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !bk_stat.mid_item)
    else $error("back end mid item with empty queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule
